// ===== rtl/core/apk_pkg.sv =====
// Shared types, widths and codes for the atlas rectangle packer.
// Used by apk_fit_unit, apk_split_unit and atlas_rectangle_packer.
package apk_pkg;

    localparam int MAX_PARTITIONS = 256;
    localparam int ADDR_W = $clog2(MAX_PARTITIONS);
    localparam int CNT_W = $clog2(MAX_PARTITIONS + 1);
    localparam int DIM_W = 13;
    localparam int SIZE_W = 14;
    localparam int POS_W = 12;
    localparam int PAD_W = 4;
    localparam int REG_W = 2;

    localparam logic [CNT_W:0] STORE_LIMIT = MAX_PARTITIONS[CNT_W:0];
    localparam logic [DIM_W-1:0] ATLAS_RESET_SIZE = 13'd1024;
    localparam logic [PAD_W-1:0] PAD_RESET = 4'd1;

    // command codes
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    // status codes
    localparam logic [1:0] STAT_PLACED = 2'd0;
    localparam logic [1:0] STAT_NO_FIT = 2'd1;
    localparam logic [1:0] STAT_FULL = 2'd2;
    localparam logic [1:0] STAT_CLEARED = 2'd3;

    // configuration register indexes
    localparam logic [REG_W-1:0] REG_ATLAS_W = 2'd0;
    localparam logic [REG_W-1:0] REG_ATLAS_H = 2'd1;
    localparam logic [REG_W-1:0] REG_PAD = 2'd2;

    typedef struct packed {
        logic [DIM_W-1:0] x;
        logic [DIM_W-1:0] y;
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
        logic             occ;
    } t_part;

    localparam int PART_W = $bits(t_part);

    // which entry the split writes in a given step
    typedef enum logic [1:0] {
        SPLIT_RIGHT,
        SPLIT_BELOW,
        SPLIT_CORNER,
        SPLIT_SLOT
    } t_split_step;

endpackage

// ===== rtl/core/apk_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module apk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/apk_fit_unit.sv =====
// Compare unit: tells whether a stored partition is free and holds a padded box.
// Depends on apk_pkg.
module apk_fit_unit (
    input  apk_pkg::t_part            i_part,
    input  logic [apk_pkg::SIZE_W-1:0] i_need_w,
    input  logic [apk_pkg::SIZE_W-1:0] i_need_h,
    output logic                      o_fit
);

    logic w_ok;
    logic h_ok;

    assign w_ok = apk_pkg::SIZE_W'(i_part.w) >= i_need_w;
    assign h_ok = apk_pkg::SIZE_W'(i_part.h) >= i_need_h;
    assign o_fit = !i_part.occ && w_ok && h_ok;

endmodule

// ===== rtl/core/apk_split_unit.sv =====
// Guillotine split arithmetic: builds the entry written in each split step.
// Depends on apk_pkg.
module apk_split_unit (
    input  apk_pkg::t_split_step       i_step,
    input  apk_pkg::t_part             i_slot,
    input  logic [apk_pkg::SIZE_W-1:0] i_need_w,
    input  logic [apk_pkg::SIZE_W-1:0] i_need_h,
    output apk_pkg::t_part             o_entry
);

    logic [apk_pkg::DIM_W-1:0] w2;
    logic [apk_pkg::DIM_W-1:0] h2;
    logic [apk_pkg::DIM_W-1:0] x_right;
    logic [apk_pkg::DIM_W-1:0] y_below;
    logic [apk_pkg::DIM_W-1:0] w_rest;
    logic [apk_pkg::DIM_W-1:0] h_rest;

    // the slot fits, so the padded size is below 2^13 here
    assign w2 = i_need_w[apk_pkg::DIM_W-1:0];
    assign h2 = i_need_h[apk_pkg::DIM_W-1:0];
    assign x_right = i_slot.x + w2;
    assign y_below = i_slot.y + h2;
    assign w_rest = i_slot.w - w2;
    assign h_rest = i_slot.h - h2;

    always_comb begin
        o_entry = '0;
        case (i_step)
            apk_pkg::SPLIT_RIGHT: begin
                o_entry = '{x: x_right, y: i_slot.y, w: w_rest, h: h2, occ: 1'b0};
            end
            apk_pkg::SPLIT_BELOW: begin
                o_entry = '{x: i_slot.x, y: y_below, w: w2, h: h_rest, occ: 1'b0};
            end
            apk_pkg::SPLIT_CORNER: begin
                o_entry = '{x: x_right, y: y_below, w: w_rest, h: h_rest, occ: 1'b0};
            end
            apk_pkg::SPLIT_SLOT: begin
                o_entry = '{x: i_slot.x, y: i_slot.y, w: w2, h: h2, occ: 1'b1};
            end
            default: begin
                o_entry = '0;
            end
        endcase
    end

endmodule

// ===== rtl/core/atlas_rectangle_packer.sv =====
// Atlas rectangle packer top level: sequencer, partition store and result register.
// Depends on apk_pkg, apk_ram, apk_fit_unit and apk_split_unit.
//
// Use: present an item on the input channel (i_in_valid / o_in_ready) with
// i_command, i_rect_width, i_rect_height. Each item yields exactly one result
// item on the output channel (o_out_valid / i_out_ready) carrying o_status,
// o_place_x, o_place_y. The configuration channel (i_cfg_valid / o_cfg_ready)
// is always ready; atlas size takes effect at the next clear.
// A clear goes straight to its result. An allocate reads the partition RAM one
// entry a cycle in insertion order and compares each entry as its read data
// returns; a fit then writes the split in four steps (right, below, corner,
// slot), unless the store lacks room for three more entries, which gives a
// full result. An allocate that fits no entry gives a no-fit result. One item
// is in work at a time; o_in_ready is high only while idle.
// Reset: one cycle after reset the block writes entry zero (whole 1024 x 1024
// atlas) and then goes idle with one partition in the store.
// Stall: a finished result waits in the output register; the next item may be
// accepted meanwhile but its result is held back until the register frees.
module atlas_rectangle_packer (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_command,
    input  logic [apk_pkg::DIM_W-1:0]          i_rect_width,
    input  logic [apk_pkg::DIM_W-1:0]          i_rect_height,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [1:0]                         o_status,
    output logic [apk_pkg::POS_W-1:0]          o_place_x,
    output logic [apk_pkg::POS_W-1:0]          o_place_y,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [apk_pkg::REG_W-1:0]          i_cfg_index,
    input  logic [apk_pkg::DIM_W-1:0]          i_cfg_data
);

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_SCAN,
        ST_SPLIT,
        ST_DONE
    } t_state;

    t_state                       r_state, n_state;
    logic [apk_pkg::DIM_W-1:0]    r_atlas_w, n_atlas_w;
    logic [apk_pkg::DIM_W-1:0]    r_atlas_h, n_atlas_h;
    logic [apk_pkg::PAD_W-1:0]    r_pad, n_pad;
    logic [apk_pkg::CNT_W-1:0]    r_count, n_count;
    logic [apk_pkg::CNT_W-1:0]    r_iss, n_iss;
    logic [apk_pkg::CNT_W-1:0]    r_cmp_idx, n_cmp_idx;
    logic                         r_cmp_vld, n_cmp_vld;
    logic [apk_pkg::ADDR_W-1:0]   r_found, n_found;
    logic [apk_pkg::SIZE_W-1:0]   r_need_w, n_need_w;
    logic [apk_pkg::SIZE_W-1:0]   r_need_h, n_need_h;
    apk_pkg::t_part               r_slot, n_slot;
    apk_pkg::t_split_step         r_step, n_step;
    logic [1:0]                   r_res_status, n_res_status;
    logic [apk_pkg::POS_W-1:0]    r_res_x, n_res_x;
    logic [apk_pkg::POS_W-1:0]    r_res_y, n_res_y;
    logic                         r_out_valid, n_out_valid;
    logic [1:0]                   r_out_status, n_out_status;
    logic [apk_pkg::POS_W-1:0]    r_out_x, n_out_x;
    logic [apk_pkg::POS_W-1:0]    r_out_y, n_out_y;

    logic                         ram_we;
    logic [apk_pkg::ADDR_W-1:0]   ram_waddr;
    apk_pkg::t_part               ram_wdata;
    logic [apk_pkg::ADDR_W-1:0]   ram_raddr;
    apk_pkg::t_part               ram_rdata;
    logic [apk_pkg::PART_W-1:0]   ram_rbits;
    logic                         fit;
    apk_pkg::t_part               split_entry;
    logic                         in_fire;
    logic                         slot_free;

    apk_ram #(
        .WIDTH  (apk_pkg::PART_W),
        .DEPTH  (apk_pkg::MAX_PARTITIONS),
        .ADDR_W (apk_pkg::ADDR_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rbits)
    );

    assign ram_rdata = apk_pkg::t_part'(ram_rbits);

    apk_fit_unit u_fit (
        .i_part   (ram_rdata),
        .i_need_w (r_need_w),
        .i_need_h (r_need_h),
        .o_fit    (fit)
    );

    apk_split_unit u_split (
        .i_step   (r_step),
        .i_slot   (r_slot),
        .i_need_w (r_need_w),
        .i_need_h (r_need_h),
        .o_entry  (split_entry)
    );

    assign o_in_ready = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_fire = i_in_valid && o_in_ready;
    assign slot_free = !r_out_valid || i_out_ready;
    assign ram_raddr = r_iss[apk_pkg::ADDR_W-1:0];

    // store write port
    always_comb begin
        ram_we = 1'b0;
        ram_waddr = '0;
        ram_wdata = split_entry;
        case (r_state)
            ST_INIT: begin
                ram_we = 1'b1;
                ram_wdata = '{x: '0, y: '0, w: apk_pkg::ATLAS_RESET_SIZE,
                              h: apk_pkg::ATLAS_RESET_SIZE, occ: 1'b0};
            end
            ST_CLEAR: begin
                ram_we = 1'b1;
                ram_wdata = '{x: '0, y: '0, w: r_atlas_w, h: r_atlas_h, occ: 1'b0};
            end
            ST_SPLIT: begin
                ram_we = 1'b1;
                case (r_step)
                    apk_pkg::SPLIT_RIGHT:  ram_waddr = r_count[apk_pkg::ADDR_W-1:0];
                    apk_pkg::SPLIT_BELOW:  ram_waddr = apk_pkg::ADDR_W'(r_count + 1'b1);
                    apk_pkg::SPLIT_CORNER: ram_waddr = apk_pkg::ADDR_W'(r_count + 2'd2);
                    default:               ram_waddr = r_found;
                endcase
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_atlas_w = r_atlas_w;
        n_atlas_h = r_atlas_h;
        n_pad = r_pad;
        n_count = r_count;
        n_iss = r_iss;
        n_cmp_idx = r_cmp_idx;
        n_cmp_vld = 1'b0;
        n_found = r_found;
        n_need_w = r_need_w;
        n_need_h = r_need_h;
        n_slot = r_slot;
        n_step = r_step;
        n_res_status = r_res_status;
        n_res_x = r_res_x;
        n_res_y = r_res_y;
        n_out_valid = r_out_valid;
        n_out_status = r_out_status;
        n_out_x = r_out_x;
        n_out_y = r_out_y;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        if (i_cfg_valid) begin
            case (i_cfg_index)
                apk_pkg::REG_ATLAS_W: n_atlas_w = i_cfg_data;
                apk_pkg::REG_ATLAS_H: n_atlas_h = i_cfg_data;
                apk_pkg::REG_PAD:     n_pad = i_cfg_data[apk_pkg::PAD_W-1:0];
                default:              n_pad = r_pad;
            endcase
        end

        case (r_state)
            ST_INIT: begin
                n_count = apk_pkg::CNT_W'(1);
                n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (in_fire) begin
                    n_need_w = apk_pkg::SIZE_W'(i_rect_width)
                             + apk_pkg::SIZE_W'({r_pad, 1'b0});
                    n_need_h = apk_pkg::SIZE_W'(i_rect_height)
                             + apk_pkg::SIZE_W'({r_pad, 1'b0});
                    n_iss = '0;
                    n_state = (i_command == apk_pkg::CMD_CLEAR) ? ST_CLEAR : ST_SCAN;
                end
            end
            ST_CLEAR: begin
                n_count = apk_pkg::CNT_W'(1);
                n_res_status = apk_pkg::STAT_CLEARED;
                n_res_x = '0;
                n_res_y = '0;
                n_state = ST_DONE;
            end
            ST_SCAN: begin
                // issue one read a cycle; compare the entry read last cycle
                if (r_iss < r_count) begin
                    n_iss = r_iss + 1'b1;
                    n_cmp_vld = 1'b1;
                    n_cmp_idx = r_iss;
                end
                if (r_cmp_vld) begin
                    if (fit) begin
                        n_cmp_vld = 1'b0;
                        n_found = r_cmp_idx[apk_pkg::ADDR_W-1:0];
                        n_slot = ram_rdata;
                        n_res_x = ram_rdata.x[apk_pkg::POS_W-1:0];
                        n_res_y = ram_rdata.y[apk_pkg::POS_W-1:0];
                        if (({1'b0, r_count} + 3'd3) > apk_pkg::STORE_LIMIT) begin
                            n_res_status = apk_pkg::STAT_FULL;
                            n_res_x = '0;
                            n_res_y = '0;
                            n_state = ST_DONE;
                        end else begin
                            n_res_status = apk_pkg::STAT_PLACED;
                            n_step = apk_pkg::SPLIT_RIGHT;
                            n_state = ST_SPLIT;
                        end
                    end else if (r_cmp_idx == r_count - apk_pkg::CNT_W'(1)) begin
                        n_cmp_vld = 1'b0;
                        n_res_status = apk_pkg::STAT_NO_FIT;
                        n_res_x = '0;
                        n_res_y = '0;
                        n_state = ST_DONE;
                    end
                end
            end
            ST_SPLIT: begin
                case (r_step)
                    apk_pkg::SPLIT_RIGHT:  n_step = apk_pkg::SPLIT_BELOW;
                    apk_pkg::SPLIT_BELOW:  n_step = apk_pkg::SPLIT_CORNER;
                    apk_pkg::SPLIT_CORNER: n_step = apk_pkg::SPLIT_SLOT;
                    default: begin
                        n_count = r_count + apk_pkg::CNT_W'(3);
                        n_state = ST_DONE;
                    end
                endcase
            end
            ST_DONE: begin
                // hold the result until the output register frees
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_status = r_res_status;
                    n_out_x = r_res_x;
                    n_out_y = r_res_y;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
            r_atlas_w <= apk_pkg::ATLAS_RESET_SIZE;
            r_atlas_h <= apk_pkg::ATLAS_RESET_SIZE;
            r_pad <= apk_pkg::PAD_RESET;
            r_count <= apk_pkg::CNT_W'(1);
            r_iss <= '0;
            r_cmp_vld <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_atlas_w <= n_atlas_w;
            r_atlas_h <= n_atlas_h;
            r_pad <= n_pad;
            r_count <= n_count;
            r_iss <= n_iss;
            r_cmp_vld <= n_cmp_vld;
            r_out_valid <= n_out_valid;
        end
        r_cmp_idx <= n_cmp_idx;
        r_found <= n_found;
        r_need_w <= n_need_w;
        r_need_h <= n_need_h;
        r_slot <= n_slot;
        r_step <= n_step;
        r_res_status <= n_res_status;
        r_res_x <= n_res_x;
        r_res_y <= n_res_y;
        r_out_status <= n_out_status;
        r_out_x <= n_out_x;
        r_out_y <= n_out_y;
    end

    assign o_out_valid = r_out_valid;
    assign o_status = r_out_status;
    assign o_place_x = r_out_x;
    assign o_place_y = r_out_y;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) && ({1'b0, r_count} <= apk_pkg::STORE_LIMIT))
        else $error("partition count out of range");

    a_split_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SPLIT) |-> (({1'b0, r_count} + 3'd3) <= apk_pkg::STORE_LIMIT))
        else $error("split started without room for three entries");

    a_compare_in_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmp_vld |-> (r_cmp_idx < r_count))
        else $error("compare on an entry past the fill count");

    a_clear_resets_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |=> (r_count == apk_pkg::CNT_W'(1)))
        else $error("clear did not leave one partition");

    a_no_result_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> (r_out_valid && $stable(r_out_status)))
        else $error("pending result lost while stalled");
`endif

endmodule
